// File: rtl/iacu_pkg.sv
// Package with the command codes, transaction types and helpers of the interval unit.
package iacu_pkg;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_AND  = 4'd3,
        CMD_SDIV = 4'd4,
        CMD_SREM = 4'd5,
        CMD_EQ   = 4'd6,
        CMD_NE   = 4'd7,
        CMD_LT   = 4'd8,
        CMD_LE   = 4'd9,
        CMD_GT   = 4'd10,
        CMD_GE   = 4'd11
    } t_cmd;

    localparam int W       = 32;
    localparam int BPS     = 4;
    localparam int NS      = W / BPS;
    localparam logic signed [W-1:0] I32_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] I32_MAX = {1'b0, {(W-1){1'b1}}};

    typedef struct packed {
        logic [3:0]          command;
        logic signed [W-1:0] lhs_lower;
        logic signed [W-1:0] lhs_upper;
        logic signed [W-1:0] rhs_lower;
        logic signed [W-1:0] rhs_upper;
        logic                lhs_is_constant;
        logic                rhs_is_constant;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] result_lower;
        logic signed [W-1:0] result_upper;
        logic                compare_known;
        logic                compare_value;
    } t_out;

    // Quotient sign and magnitude work held in each divider stage.
    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] quo;
        logic [W-1:0] num;
        logic         neg;
    } t_div;

endpackage

// File: rtl/iacu_divider.sv
// Pipelined unsigned restoring divider, a few quotient bits per stage, signs applied at the end.
module iacu_divider (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [31:0]    i_num_a,
    input  logic signed [31:0]    i_num_b,
    input  logic signed [31:0]    i_den,
    output logic                  o_valid,
    output logic signed [31:0]    o_quo_a,
    output logic signed [31:0]    o_quo_b
);
    import iacu_pkg::*;

    t_div         r_a [NS+1];
    t_div         r_b [NS+1];
    logic [W-1:0] r_d [NS];
    logic         r_v [NS+1];

    function automatic t_div init(input logic signed [W-1:0] n, input logic signed [W-1:0] d);
        t_div x;
        x.rem = '0;
        x.quo = '0;
        x.num = n[W-1] ? W'(-n) : W'(n);
        x.neg = n[W-1] ^ d[W-1];
        return x;
    endfunction

    function automatic t_div step(input t_div x, input logic [W-1:0] d);
        t_div         y;
        logic [W:0]   t;
        y = x;
        for (int k = 0; k < BPS; k++) begin
            t = {y.rem, y.num[W-1]};
            y.num = {y.num[W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                y.quo = {y.quo[W-2:0], 1'b1};
            end else begin
                y.quo = {y.quo[W-2:0], 1'b0};
            end
            y.rem = t[W-1:0];
        end
        return y;
    endfunction

    always_ff @(posedge i_clk) begin
        r_a[0] <= init(i_num_a, i_den);
        r_b[0] <= init(i_num_b, i_den);
        r_d[0] <= i_den[W-1] ? W'(-i_den) : W'(i_den);
        for (int s = 0; s < NS; s++) begin
            r_a[s+1] <= step(r_a[s], r_d[s]);
            r_b[s+1] <= step(r_b[s], r_d[s]);
        end
        for (int s = 0; s < NS - 1; s++) begin
            r_d[s+1] <= r_d[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) r_v[s] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int s = 0; s < NS; s++) r_v[s+1] <= r_v[s];
        end
    end

    assign o_valid = r_v[NS];
    assign o_quo_a = r_a[NS].neg ? -$signed(r_a[NS].quo) : $signed(r_a[NS].quo);
    assign o_quo_b = r_b[NS].neg ? -$signed(r_b[NS].quo) : $signed(r_b[NS].quo);

endmodule

// File: rtl/interval_arith_compare_unit_core.sv
// Top level of the pipelined 32-bit signed interval arithmetic and compare unit.
//  channel  | ports                   | handshake
//  command  | i_start, i_item, o_busy | taken when i_start high and o_busy low
//  result   | o_done, o_result        | o_done high for one cycle per transaction
// One transaction may enter every cycle; o_busy is always low.
// o_done rises after one input register, the nine registers of the divider and one
// output register, counted from the accepting edge.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so results leave in order without back-pressure.
module interval_arith_compare_unit_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  iacu_pkg::t_in   i_item,
    output logic            o_busy,
    output logic            o_done,
    output iacu_pkg::t_out  o_result
);
    import iacu_pkg::*;

    localparam int DL = NS - 1;

    typedef struct packed {
        logic [3:0]          cmd;
        logic signed [W-1:0] al;
        logic signed [W-1:0] ah;
        logic signed [W-1:0] bl;
        logic signed [W-1:0] bh;
        logic                ac;
        logic                bc;
    } t_s1;

    typedef struct packed {
        logic [3:0]          cmd;
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        logic                k;
        logic                v;
        logic                divok;
    } t_s2;

    t_s1 r_s1;
    logic r_v1;
    logic signed [2*W-1:0] r_p [4];
    t_s2 r_s2, r_s3;
    t_s2 r_dq [DL];
    logic signed [2*W-1:0] r_mn, r_mx;
    t_s2 n_s2;
    logic dv;
    logic signed [W-1:0] qa, qb;
    t_out n_out, r_out;
    logic r_done;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_s1.cmd <= i_item.command;
        r_s1.al  <= i_item.lhs_lower;
        r_s1.ah  <= i_item.lhs_is_constant ? i_item.lhs_lower : i_item.lhs_upper;
        r_s1.bl  <= i_item.rhs_lower;
        r_s1.bh  <= i_item.rhs_is_constant ? i_item.rhs_lower : i_item.rhs_upper;
        r_s1.ac  <= i_item.lhs_is_constant;
        r_s1.bc  <= i_item.rhs_is_constant;
    end

    always_comb begin
        logic signed [W:0] s0, s1, m, mk;
        logic same, apart;
        n_s2 = '0;
        n_s2.cmd = r_s1.cmd;
        n_s2.lo = I32_MIN;
        n_s2.hi = I32_MAX;
        same = (r_s1.al == r_s1.ah) && (r_s1.bl == r_s1.bh) && (r_s1.al == r_s1.bl);
        apart = (r_s1.ah < r_s1.bl) || (r_s1.bh < r_s1.al);
        s0 = '0;
        s1 = '0;
        m = r_s1.bl[W-1] ? -(W+1)'(r_s1.bl) : (W+1)'(r_s1.bl);
        mk = r_s1.bc ? (W+1)'(r_s1.bl) : (W+1)'(r_s1.al);
        case (r_s1.cmd)
            CMD_ADD: begin
                s0 = (W+1)'(r_s1.al) + (W+1)'(r_s1.bl);
                s1 = (W+1)'(r_s1.ah) + (W+1)'(r_s1.bh);
            end
            CMD_SUB: begin
                s0 = (W+1)'(r_s1.al) - (W+1)'(r_s1.bh);
                s1 = (W+1)'(r_s1.ah) - (W+1)'(r_s1.bl);
            end
            default: ;
        endcase
        case (r_s1.cmd)
            CMD_ADD, CMD_SUB: begin
                if (s0 >= (W+1)'(I32_MIN) && s1 <= (W+1)'(I32_MAX) && s0 <= s1) begin
                    n_s2.lo = s0[W-1:0];
                    n_s2.hi = s1[W-1:0];
                end
            end
            CMD_AND: begin
                if ((r_s1.ac || r_s1.bc) && !mk[W]) begin
                    n_s2.lo = '0;
                    n_s2.hi = mk[W-1:0];
                end
            end
            CMD_SDIV: begin
                n_s2.divok = r_s1.bc && r_s1.bl != 0 &&
                    !(r_s1.bl == -1 && (r_s1.al == I32_MIN || r_s1.ah == I32_MIN));
            end
            CMD_SREM: begin
                if (r_s1.bc && r_s1.bl != 0) begin
                    if (!r_s1.al[W-1]) begin
                        n_s2.lo = '0;
                        n_s2.hi = W'(m - 1);
                    end else if (r_s1.ah <= 0) begin
                        n_s2.lo = W'(1 - m);
                        n_s2.hi = '0;
                    end else begin
                        n_s2.lo = W'(1 - m);
                        n_s2.hi = W'(m - 1);
                    end
                end
            end
            CMD_EQ: begin
                n_s2.k = same || apart;
                n_s2.v = same;
            end
            CMD_NE: begin
                n_s2.k = same || apart;
                n_s2.v = !same && apart;
            end
            CMD_LT: begin
                n_s2.k = (r_s1.ah < r_s1.bl) || (r_s1.al >= r_s1.bh);
                n_s2.v = r_s1.ah < r_s1.bl;
            end
            CMD_LE: begin
                n_s2.k = (r_s1.ah <= r_s1.bl) || (r_s1.al > r_s1.bh);
                n_s2.v = r_s1.ah <= r_s1.bl;
            end
            CMD_GT: begin
                n_s2.k = (r_s1.al > r_s1.bh) || (r_s1.ah <= r_s1.bl);
                n_s2.v = r_s1.al > r_s1.bh;
            end
            CMD_GE: begin
                n_s2.k = (r_s1.al >= r_s1.bh) || (r_s1.ah < r_s1.bl);
                n_s2.v = r_s1.al >= r_s1.bh;
            end
            default: ;
        endcase
        if (r_s1.cmd >= CMD_EQ && r_s1.cmd <= CMD_GE) begin
            n_s2.lo = '0;
            n_s2.hi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
        r_p[0] <= r_s1.al * r_s1.bl;
        r_p[1] <= r_s1.al * r_s1.bh;
        r_p[2] <= r_s1.ah * r_s1.bl;
        r_p[3] <= r_s1.ah * r_s1.bh;
        r_mn <= (r_p[0] < r_p[1] ? r_p[0] : r_p[1]) < (r_p[2] < r_p[3] ? r_p[2] : r_p[3])
              ? (r_p[0] < r_p[1] ? r_p[0] : r_p[1]) : (r_p[2] < r_p[3] ? r_p[2] : r_p[3]);
        r_mx <= (r_p[0] > r_p[1] ? r_p[0] : r_p[1]) > (r_p[2] > r_p[3] ? r_p[2] : r_p[3])
              ? (r_p[0] > r_p[1] ? r_p[0] : r_p[1]) : (r_p[2] > r_p[3] ? r_p[2] : r_p[3]);
        r_s3 <= r_s2;
        if (r_s3.cmd == CMD_MUL && r_mn >= (2*W)'(I32_MIN) && r_mx <= (2*W)'(I32_MAX)
                && r_mn <= r_mx) begin
            r_dq[0].lo <= r_mn[W-1:0];
            r_dq[0].hi <= r_mx[W-1:0];
            {r_dq[0].cmd, r_dq[0].k, r_dq[0].v, r_dq[0].divok} <=
                {r_s3.cmd, r_s3.k, r_s3.v, r_s3.divok};
        end else begin
            r_dq[0] <= r_s3;
        end
        for (int s = 1; s < DL; s++) r_dq[s] <= r_dq[s-1];
    end

    iacu_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_num_a (r_s1.al),
        .i_num_b (r_s1.ah),
        .i_den   (r_s1.bl),
        .o_valid (dv),
        .o_quo_a (qa),
        .o_quo_b (qb)
    );

    always_comb begin
        n_out.result_lower  = r_dq[DL-1].lo;
        n_out.result_upper  = r_dq[DL-1].hi;
        n_out.compare_known = r_dq[DL-1].k;
        n_out.compare_value = r_dq[DL-1].k && r_dq[DL-1].v;
        if (r_dq[DL-1].cmd == CMD_SDIV && r_dq[DL-1].divok) begin
            n_out.result_lower = qa < qb ? qa : qb;
            n_out.result_upper = qa < qb ? qb : qa;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= dv;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule
